FILE: src/kvt_pkg.sv
// kvt_pkg: shared types and codes for the key/value table
// request codes, result codes and the token that walks the cell chain
// no dependencies
package kvt_pkg;

  // default number of table entries
  localparam int unsigned ENTRIES_DEF = 16;

  // request kinds
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // result kinds
  localparam logic [1:0] ST_VALUE     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_CREATED   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // request token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic               hit;
    logic signed [31:0] hit_value;
    logic               free_found;
  } kvt_tok_t;

  // broadcast that stores a new pair in the claimed free cell
  typedef struct packed {
    logic               vld;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kvt_commit_t;

endpackage

FILE: src/key_value_table.sv
// key_value_table: top level of the key/value table
// request control, cell chain and result register
// depends on kvt_pkg and kvt_cell
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind
//   (read, write, delete), tdata the key and the value. Results leave on
//   the m_axis channel: tuser carries the result kind, tdata the value.
//   A write that updates a present key and a request of the unused kind
//   give no result.
//   A request walks the row of ENTRIES cells, one cell per cycle; each
//   cell compares against its own entry and updates or frees it in place.
//   New pairs go to the lowest free cell after the walk, through the
//   chain end register and the commit register; the result goes from
//   the chain end register into the output register. s_axis_tready is
//   high only while no request is in work.
//   Reset empties the table at once. A result waiting on a stalled
//   receiver stays in the output register; the next request is taken
//   meanwhile and its result is held at the chain end until the output
//   register frees.
module key_value_table #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key [31:0], value [63:32]
  input  logic [1:0]  s_axis_tuser,  // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value [31:0]
  output logic [1:0]  m_axis_tuser   // status [1:0]
);
  import kvt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_e;

  state_e             state_q;
  kvt_tok_t           tok0_q;
  kvt_tok_t           fin_q;
  kvt_commit_t        commit_q;
  logic               out_vld_q;
  logic [1:0]         out_status_q;
  logic signed [31:0] out_value_q;

  kvt_tok_t           tok [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vld;

  logic               res_vld;
  logic [1:0]         res_status;
  logic signed [31:0] res_value;
  logic               res_commit;
  logic               out_free;
  logic               out_load;
  logic               s_req;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_req         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign out_load      = (state_q == ST_DONE) && out_free;

  // cell chain
  assign tok[0] = tok0_q;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1]),
      .commit_i (commit_q)
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  // result from the finished token
  always_comb begin
    res_vld    = 1'b0;
    res_status = ST_NOT_FOUND;
    res_value  = '0;
    res_commit = 1'b0;
    unique case (fin_q.op)
      OP_READ, OP_DELETE: begin
        res_vld = 1'b1;
        if (fin_q.hit) begin
          res_status = ST_VALUE;
          res_value  = fin_q.hit_value;
        end
      end
      OP_WRITE: begin
        if (!fin_q.hit) begin
          res_vld = 1'b1;
          if (fin_q.free_found) begin
            res_status = ST_CREATED;
            res_value  = fin_q.key;
            res_commit = 1'b1;
          end else begin
            res_status = ST_FULL;
          end
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  // request control, chain end capture and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tok0_q       <= '0;
      fin_q        <= '0;
      commit_q     <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= ST_VALUE;
      out_value_q  <= '0;
    end else begin
      tok0_q.vld   <= s_req;
      commit_q.vld <= out_load && res_commit;
      out_vld_q    <= (out_load && res_vld) || (out_vld_q && !m_axis_tready);
      unique case (state_q)
        ST_IDLE: begin
          if (s_req) begin
            tok0_q.op         <= s_axis_tuser;
            tok0_q.key        <= s_axis_tdata[31:0];
            tok0_q.value      <= s_axis_tdata[63:32];
            tok0_q.hit        <= 1'b0;
            tok0_q.hit_value  <= '0;
            tok0_q.free_found <= 1'b0;
            state_q           <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (tok[ENTRIES].vld) begin
            fin_q   <= tok[ENTRIES];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (res_vld) begin
              out_status_q <= res_status;
              out_value_q  <= res_value;
            end
            commit_q.key   <= fin_q.key;
            commit_q.value <= fin_q.value;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  // at most one request walks the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the cell chain");

  // the chain end only fires while a request is in work
  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[ENTRIES].vld |-> (state_q == ST_BUSY))
    else $error("token left the chain outside the busy state");

  // a store of a new pair follows a finished request
  a_commit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_q.vld |-> ($past(state_q) == ST_DONE) && (state_q == ST_IDLE))
    else $error("commit without a finished request");

  // a result is loaded only when leaving the done state
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_DONE))
    else $error("result appeared without a finished request");

endmodule

FILE: src/kvt_cell.sv
// kvt_cell: one table entry plus one stage of the request chain
// looks up, updates or frees its entry as the token passes
// depends on kvt_pkg
module kvt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kvt_pkg::kvt_tok_t    tok_i,
  output kvt_pkg::kvt_tok_t    tok_o,
  input  kvt_pkg::kvt_commit_t commit_i
);
  import kvt_pkg::*;

  logic               valid_q, valid_d;
  logic               claim_q, claim_d;
  logic signed [31:0] key_q;
  logic signed [31:0] value_q;
  kvt_tok_t           tok_q, tok_d;
  logic               hit_here;
  logic               free_here;
  logic               take_commit;

  // match and first-free detection for the passing token
  always_comb begin
    hit_here    = tok_i.vld && valid_q && (key_q == tok_i.key);
    free_here   = tok_i.vld && !valid_q && !tok_i.free_found;
    take_commit = commit_i.vld && claim_q;
    tok_d       = tok_i;
    if (hit_here) begin
      tok_d.hit       = 1'b1;
      tok_d.hit_value = value_q;
    end
    if (free_here) begin
      tok_d.free_found = 1'b1;
    end
  end

  // valid bit and claim flag
  always_comb begin
    valid_d = valid_q;
    claim_d = claim_q;
    if (tok_i.vld) begin
      claim_d = free_here;
    end
    if (hit_here && (tok_i.op == OP_DELETE)) begin
      valid_d = 1'b0;
    end
    if (take_commit) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      claim_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      claim_q <= claim_d;
      tok_q   <= tok_d;
    end
  end

  // stored pair, written on create or update
  always_ff @(posedge clk_i) begin
    if (take_commit) begin
      key_q   <= commit_i.key;
      value_q <= commit_i.value;
    end else if (hit_here && (tok_i.op == OP_WRITE)) begin
      value_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule
